[rtl/core/fdre_pkg.sv]
`timescale 1ns / 1ps

package fdre_pkg;

	// field widths
	localparam int INT_W   = 12;
	localparam int FRAC_W  = 20;
	localparam int NUM_W   = FRAC_W + 7;      // 128 * b
	localparam int P1_W    = 18;
	localparam int CNT_W   = 5;

	// request commands
	localparam logic CMD_PLL    = 1'b0;
	localparam logic CMD_OUTPUT = 1'b1;

	localparam logic       PLL_A      = 1'b0;
	localparam logic [1:0] CH_INVALID = 2'd3;

	// result status
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOINIT  = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DEVICE_READY = 2'd0;
	localparam logic [1:0] CFG_RDIV0        = 2'd1;
	localparam logic [1:0] CFG_RDIV1        = 2'd2;
	localparam logic [1:0] CFG_RDIV2        = 2'd3;

	// device register map
	localparam logic [7:0] REG_PLL_A_BASE  = 8'd26;
	localparam logic [7:0] REG_PLL_B_BASE  = 8'd34;
	localparam logic [7:0] REG_MS0_BASE    = 8'd42;
	localparam logic [7:0] REG_PLL_RESET   = 8'd177;
	localparam logic [7:0] REG_CLK_CTRL0   = 8'd16;
	localparam logic [7:0] PLL_RESET_BOTH  = 8'hA0;
	localparam logic [7:0] CLK_CTRL_BASE   = 8'h0F;
	localparam logic [7:0] CLK_CTRL_PLLB   = 8'h20;
	localparam logic [7:0] CLK_CTRL_INT    = 8'h40;

	localparam logic [P1_W-1:0]  P1_OFFSET = 18'd512;
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
	localparam logic [3:0]       BEAT_LAST = 4'd8;

	// PLL range 15..90, output range 4..2048
	localparam logic [INT_W-1:0] PLL_INT_MIN = 12'd15;
	localparam logic [INT_W-1:0] PLL_INT_MAX = 12'd90;
	localparam logic [INT_W-1:0] MS_INT_MIN  = 12'd4;
	localparam logic [INT_W-1:0] MS_INT_MAX  = 12'd2048;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_P1,
		ST_EMIT,
		ST_ERR
	} state_t;

endpackage

[rtl/core/fdre_if.sv]
`timescale 1ns / 1ps

interface fdre_req_if import fdre_pkg::*;;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [1:0]        channel;
	logic              pll_select;
	logic [INT_W-1:0]  int_part;
	logic [FRAC_W-1:0] frac_num;
	logic [FRAC_W-1:0] frac_den;

	modport source (output valid, cmd, channel, pll_select, int_part, frac_num, frac_den,
		input ready);
	modport sink (input valid, cmd, channel, pll_select, int_part, frac_num, frac_den,
		output ready);
endinterface

interface fdre_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] reg_addr;
	logic [7:0] reg_data;
	logic [1:0] status;
	logic       last;

	modport source (output valid, reg_addr, reg_data, status, last, input ready);
	modport sink (input valid, reg_addr, reg_data, status, last, output ready);
endinterface

[rtl/core/fractional_divider_register_encoder_top.sv]
`timescale 1ns / 1ps
// After acceptance, a valid request runs a 27-step bit-serial restoring division of
//   128*b by c, then a P1 step, then gives 9 beats.
// An error request gives its single beat the cycle after acceptance.
// One request at a time: the next is taken only after the last beat of this one.
// Reset (arst_n low, asynchronous): idle, device not ready, R codes 0, PLL flags clear.
module fractional_divider_register_encoder_top import fdre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fdre_req_if.sink    request,
	fdre_res_if.source  result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	// configuration and flags
	logic       device_ready_q;
	logic [2:0] rdiv0_q, rdiv1_q, rdiv2_q;
	logic       pll_a_q, pll_b_q;

	// captured request
	logic              cmd_q;
	logic [1:0]        ch_q;
	logic              pll_q;
	logic              bzero_q;
	logic [2:0]        rdiv_sel_q;
	logic [INT_W-1:0]  int_q;
	logic [FRAC_W-1:0] c_q;
	logic [7:0]        base_q;
	logic [1:0]        status_q;

	// divider: num_q shifts dividend out at the top and quotient bits in at the bottom
	logic [NUM_W-1:0]  num_q;
	logic [FRAC_W-1:0] rem_q;
	logic [P1_W-1:0]   p1_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [FRAC_W:0] trial, diff;
	logic            ge;

	logic accept, cfg_wr, req_bad, src_ok;
	logic [2:0] rdiv_in;
	logic [7:0] base_in;

	assign accept = request.valid && request.ready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, c_q};
	assign diff  = trial - {1'b0, c_q};

	assign src_ok = (request.pll_select == PLL_A) ? pll_a_q : pll_b_q;

	always_comb begin
		if (request.cmd == CMD_PLL) begin
			req_bad = (request.int_part < PLL_INT_MIN) || (request.int_part > PLL_INT_MAX) ||
				(request.frac_den == '0);
		end else begin
			req_bad = (request.channel == CH_INVALID) || (request.int_part < MS_INT_MIN) ||
				(request.int_part > MS_INT_MAX) || (request.frac_den == '0) || !src_ok;
		end
	end

	always_comb begin
		case (request.channel)
			2'd0:    rdiv_in = rdiv0_q;
			2'd1:    rdiv_in = rdiv1_q;
			2'd2:    rdiv_in = rdiv2_q;
			default: rdiv_in = 3'd0;
		endcase
	end

	always_comb begin
		if (request.cmd == CMD_PLL) begin
			base_in = (request.pll_select == PLL_A) ? REG_PLL_A_BASE : REG_PLL_B_BASE;
		end else begin
			base_in = REG_MS0_BASE + {3'd0, request.channel, 3'd0};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (!device_ready_q || req_bad) ? ST_ERR : ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) state_d = ST_P1;
			end
			ST_P1:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (result.ready && cnt_q[3:0] == BEAT_LAST) state_d = ST_IDLE;
			end
			ST_ERR: begin
				if (result.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs; result payload is picked from held registers by beat number
	always_comb begin
		request.ready   = 1'b0;
		result.valid    = 1'b0;
		result.reg_addr = 8'd0;
		result.reg_data = 8'd0;
		result.status   = STATUS_OK;
		result.last     = 1'b0;
		case (state_q)
			ST_IDLE: request.ready = 1'b1;
			ST_ERR: begin
				result.valid  = 1'b1;
				result.status = status_q;
				result.last   = 1'b1;
			end
			ST_EMIT: begin
				result.valid    = 1'b1;
				result.reg_addr = base_q + {5'd0, cnt_q[2:0]};
				case (cnt_q[3:0])
					4'd0: result.reg_data = c_q[15:8];
					4'd1: result.reg_data = c_q[7:0];
					4'd2: result.reg_data = {1'b0, rdiv_sel_q, 2'b00, p1_q[17:16]};
					4'd3: result.reg_data = p1_q[15:8];
					4'd4: result.reg_data = p1_q[7:0];
					4'd5: result.reg_data = {c_q[19:16], rem_q[19:16]};
					4'd6: result.reg_data = rem_q[15:8];
					4'd7: result.reg_data = rem_q[7:0];
					4'd8: begin
						result.last = 1'b1;
						if (cmd_q == CMD_PLL) begin
							result.reg_addr = REG_PLL_RESET;
							result.reg_data = PLL_RESET_BOTH;
						end else begin
							result.reg_addr = REG_CLK_CTRL0 + {6'd0, ch_q};
							result.reg_data = CLK_CTRL_BASE |
								(pll_q ? CLK_CTRL_PLLB : 8'h00) |
								(bzero_q ? CLK_CTRL_INT : 8'h00);
						end
					end
					default: result.reg_data = 8'd0;
				endcase
			end
			default: ;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			device_ready_q <= 1'b0;
			rdiv0_q        <= 3'd0;
			rdiv1_q        <= 3'd0;
			rdiv2_q        <= 3'd0;
			pll_a_q        <= 1'b0;
			pll_b_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: cnt_q <= '0;
				ST_DIV:  cnt_q <= (cnt_q == DIV_LAST) ? '0 : cnt_q + 1'b1;
				ST_EMIT: begin
					if (result.ready) cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
			// flag marks the PLL as programmed once a good request for it is taken while ready
			if (accept && device_ready_q && !req_bad && request.cmd == CMD_PLL) begin
				if (request.pll_select == PLL_A) pll_a_q <= 1'b1;
				else pll_b_q <= 1'b1;
			end
			if (cfg_wr) begin
				case (paddr[3:2])
					CFG_DEVICE_READY: begin
						device_ready_q <= pwdata[0];
						if (pwdata[0]) begin
							pll_a_q <= 1'b0;
							pll_b_q <= 1'b0;
						end
					end
					CFG_RDIV0: rdiv0_q <= pwdata[2:0];
					CFG_RDIV1: rdiv1_q <= pwdata[2:0];
					CFG_RDIV2: rdiv2_q <= pwdata[2:0];
					default: ;
				endcase
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q      <= request.cmd;
					ch_q       <= request.channel;
					pll_q      <= request.pll_select;
					bzero_q    <= (request.frac_num == '0);
					rdiv_sel_q <= (request.cmd == CMD_PLL) ? 3'd0 : rdiv_in;
					int_q      <= request.int_part;
					c_q        <= request.frac_den;
					base_q     <= base_in;
					num_q      <= {request.frac_num, 7'd0};
					rem_q      <= '0;
					status_q   <= device_ready_q ? STATUS_INVALID : STATUS_NOINIT;
				end
			end
			ST_DIV: begin
				rem_q <= ge ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
				num_q <= {num_q[NUM_W-2:0], ge};
			end
			ST_P1: begin
				// 128*a + q - 512, kept to 18 bits
				p1_q <= {int_q[P1_W-8:0], 7'd0} + num_q[P1_W-1:0] - P1_OFFSET;
			end
			default: ;
		endcase
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			CFG_DEVICE_READY: prdata = {31'd0, device_ready_q};
			CFG_RDIV0:        prdata = {29'd0, rdiv0_q};
			CFG_RDIV1:        prdata = {29'd0, rdiv1_q};
			CFG_RDIV2:        prdata = {29'd0, rdiv2_q};
			default:          prdata = 32'd0;
		endcase
	end

	// one request in flight: ready drops right after a request is taken in
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> !request.ready)
		else $error("request accepted while busy");

	// partial remainder stays below the divisor through the division
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_P1) |-> rem_q < c_q)
		else $error("remainder out of range");

	// never more than nine beats
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> cnt_q[3:0] <= BEAT_LAST)
		else $error("beat counter overrun");

	// PLL A flag only comes up from an accepted PLL A request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pll_a_q) |-> $past(accept && request.cmd == CMD_PLL &&
			request.pll_select == PLL_A))
		else $error("PLL A flag set without request");

endmodule
